### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLKD(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/gpgs_pkg.sv
// Shared types, codes and reset constants of the geared position gain scheduler.
// No dependencies.
package gpgs_pkg;

  localparam int unsigned ANGLE_BITS_DEFAULT = 32;

  typedef enum logic [1:0] {
    ACT_RUN        = 2'd0,
    ACT_HOLD       = 2'd1,
    ACT_STOP       = 2'd2,
    ACT_SET_TARGET = 2'd3
  } action_e;

  localparam int unsigned CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAR_ERR_LIMIT      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NEAR_HYST          = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARRIVE_POS_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARRIVE_SPEED_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARRIVE_FRAMES      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GEAR_RATIO         = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GEAR_RATIO_RECIP   = 3'd6;

  typedef struct packed {
    logic [30:0] far_err_limit;
    logic [30:0] near_hyst;
    logic [30:0] arrive_pos_limit;
    logic [30:0] arrive_speed_limit;
    logic [7:0]  arrive_frames;
    logic [15:0] gear_ratio;
    logic [15:0] gear_ratio_recip;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    far_err_limit:      31'd19661,
    near_hyst:          31'd3277,
    arrive_pos_limit:   31'd5243,
    arrive_speed_limit: 31'd9830,
    arrive_frames:      8'd5,
    gear_ratio:         16'd1620,
    gear_ratio_recip:   16'd10354
  };

  // Control part of a transaction held in the input register.
  typedef struct packed {
    logic    valid;
    action_e action;
    logic    comm_ok;
  } item_ctl_t;

endpackage

### rtl/core/gpgs_sat.sv
// Signed saturation from IW bits down to OW bits (IW >= OW).
// No dependencies.
module gpgs_sat #(
  parameter int unsigned IW = 33,
  parameter int unsigned OW = 32
) (
  input  logic [IW-1:0] in_i,
  output logic [OW-1:0] out_o
);

  logic [IW-OW:0] upper;
  logic           fits;

  assign upper = in_i[IW-1:OW-1];
  assign fits  = (&upper) | ~(|upper);
  assign out_o = fits ? in_i[OW-1:0] : {in_i[IW-1], {(OW-1){~in_i[IW-1]}}};

endmodule

### rtl/core/gpgs_cfg.sv
// Configuration register file, written over a valid/ready channel.
// Depends on gpgs_pkg.
module gpgs_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [gpgs_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  output logic                                 cfg_ready_o,
  output gpgs_pkg::cfg_t                       cfg_o
);

  gpgs_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gpgs_pkg::CFG_FAR_ERR_LIMIT:      cfg_d.far_err_limit      = cfg_data_i[30:0];
        gpgs_pkg::CFG_NEAR_HYST:          cfg_d.near_hyst          = cfg_data_i[30:0];
        gpgs_pkg::CFG_ARRIVE_POS_LIMIT:   cfg_d.arrive_pos_limit   = cfg_data_i[30:0];
        gpgs_pkg::CFG_ARRIVE_SPEED_LIMIT: cfg_d.arrive_speed_limit = cfg_data_i[30:0];
        gpgs_pkg::CFG_ARRIVE_FRAMES:      cfg_d.arrive_frames      = cfg_data_i[7:0];
        gpgs_pkg::CFG_GEAR_RATIO:         cfg_d.gear_ratio         = cfg_data_i[15:0];
        gpgs_pkg::CFG_GEAR_RATIO_RECIP:   cfg_d.gear_ratio_recip   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gpgs_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/gpgs_front.sv
// Input register: captures a transaction and the load-side scaling of the
// rotor angle and speed. Depends on gpgs_pkg and gpgs_sat.
module gpgs_front #(
  parameter int unsigned AngleBits = gpgs_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      in_valid_i,
  input  logic [1:0]                action_i,
  input  logic                      comm_ok_i,
  input  logic signed [31:0]        rotor_position_i,
  input  logic signed [31:0]        rotor_speed_i,
  input  logic signed [31:0]        new_target_i,
  input  logic [15:0]               recip_i,
  output gpgs_pkg::item_ctl_t       ctl_o,
  output logic signed [31:0]        rotor_position_o,
  output logic signed [31:0]        new_target_o,
  output logic signed [AngleBits-1:0] load_position_o,
  output logic signed [AngleBits-1:0] load_speed_o
);

  localparam int unsigned PW = (AngleBits > 32) ? AngleBits : 32;

  logic signed [48:0]          pos_prod, spd_prod;
  logic signed [31:0]          pos_shift, spd_shift;
  logic signed [PW-1:0]        pos_ext, spd_ext;
  logic [AngleBits-1:0]        pos_sat, spd_sat;

  logic                        vld_q;
  gpgs_pkg::action_e           action_q;
  logic                        ok_q;
  logic signed [31:0]          rpos_q, ntgt_q;
  logic signed [AngleBits-1:0] lpos_q, lspd_q;

  // Floor of x * recip / 2^16; the result always fits 32 bits.
  assign pos_prod  = rotor_position_i * $signed({1'b0, recip_i});
  assign spd_prod  = rotor_speed_i * $signed({1'b0, recip_i});
  assign pos_shift = pos_prod[47:16];
  assign spd_shift = spd_prod[47:16];
  assign pos_ext   = PW'(pos_shift);
  assign spd_ext   = PW'(spd_shift);

  gpgs_sat #(.IW(PW), .OW(AngleBits)) u_sat_pos (.in_i(pos_ext), .out_o(pos_sat));
  gpgs_sat #(.IW(PW), .OW(AngleBits)) u_sat_spd (.in_i(spd_ext), .out_o(spd_sat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && in_valid_i) begin
      action_q <= gpgs_pkg::action_e'(action_i);
      ok_q     <= comm_ok_i;
      rpos_q   <= rotor_position_i;
      ntgt_q   <= new_target_i;
      lpos_q   <= $signed(pos_sat);
      lspd_q   <= $signed(spd_sat);
    end
  end

  assign ctl_o.valid      = vld_q;
  assign ctl_o.action     = action_q;
  assign ctl_o.comm_ok    = ok_q;
  assign rotor_position_o = rpos_q;
  assign new_target_o     = ntgt_q;
  assign load_position_o  = lpos_q;
  assign load_speed_o     = lspd_q;

endmodule

### rtl/core/gpgs_core.sv
// Scheduler state and its update: target, command, load values, gain flag
// and arrival counter. Depends on gpgs_pkg and gpgs_sat.
module gpgs_core #(
  parameter int unsigned AngleBits = gpgs_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  gpgs_pkg::item_ctl_t         ctl_i,
  input  logic signed [31:0]          rotor_position_i,
  input  logic signed [31:0]          new_target_i,
  input  logic signed [AngleBits-1:0] load_position_i,
  input  logic signed [AngleBits-1:0] load_speed_i,
  input  gpgs_pkg::cfg_t              cfg_i,
  output logic                        status_o,
  output logic [31:0]                 rotor_command_o,
  output logic                        use_far_gain_o,
  output logic [31:0]                 target_position_o,
  output logic [31:0]                 load_position_o,
  output logic                        arrived_o
);

  localparam int unsigned PW = (AngleBits > 32) ? AngleBits : 32;
  localparam int unsigned CW = (AngleBits + 2 > 33) ? AngleBits + 2 : 33;
  localparam int unsigned MW = AngleBits + 17;

  logic signed [AngleBits-1:0] target_q, target_d;
  logic signed [AngleBits-1:0] command_q, command_d;
  logic signed [AngleBits-1:0] load_q, load_d;
  logic signed [AngleBits-1:0] speed_q, speed_d;
  logic                        approach_q, approach_d;
  logic [7:0]                  count_q, count_d;

  logic                        is_run, is_hold, is_stop, is_set, run_ok;
  logic signed [MW-1:0]        cmd_prod;
  logic [AngleBits+8:0]        cmd_shift;
  logic [AngleBits-1:0]        cmd_run, hold_cmd, set_tgt;
  logic signed [PW-1:0]        rpos_ext, ntgt_ext;
  logic signed [CW-1:0]        diff, err, spd_ext, spd_abs;
  logic signed [CW-1:0]        brake, near_lim, pos_lim, spd_lim;
  logic                        qualify;
  logic signed [PW-1:0]        cmd_out_ext, tgt_out_ext, load_out_ext;

  assign is_run  = (ctl_i.action == gpgs_pkg::ACT_RUN);
  assign is_hold = (ctl_i.action == gpgs_pkg::ACT_HOLD);
  assign is_stop = (ctl_i.action == gpgs_pkg::ACT_STOP);
  assign is_set  = (ctl_i.action == gpgs_pkg::ACT_SET_TARGET);
  assign run_ok  = is_run && ctl_i.comm_ok;

  // Rotor command: floor(target * ratio / 2^8), saturated.
  assign cmd_prod  = target_q * $signed({1'b0, cfg_i.gear_ratio});
  assign cmd_shift = cmd_prod[MW-1:8];
  gpgs_sat #(.IW(AngleBits + 9), .OW(AngleBits)) u_sat_cmd (
    .in_i(cmd_shift), .out_o(cmd_run)
  );

  assign rpos_ext = PW'(rotor_position_i);
  assign ntgt_ext = PW'(new_target_i);
  gpgs_sat #(.IW(PW), .OW(AngleBits)) u_sat_hold (.in_i(rpos_ext), .out_o(hold_cmd));
  gpgs_sat #(.IW(PW), .OW(AngleBits)) u_sat_set  (.in_i(ntgt_ext), .out_o(set_tgt));

  assign load_d  = run_ok ? load_position_i : load_q;
  assign speed_d = run_ok ? load_speed_i : speed_q;

  assign diff     = CW'(target_q) - CW'(load_d);
  assign err      = diff[CW-1] ? -diff : diff;
  assign spd_ext  = CW'(speed_d);
  assign spd_abs  = spd_ext[CW-1] ? -spd_ext : spd_ext;
  assign brake    = CW'({1'b0, cfg_i.far_err_limit});
  assign near_lim = brake - CW'({1'b0, cfg_i.near_hyst});
  assign pos_lim  = CW'({1'b0, cfg_i.arrive_pos_limit});
  assign spd_lim  = CW'({1'b0, cfg_i.arrive_speed_limit});
  assign qualify  = (err < pos_lim) && (spd_abs < spd_lim);

  always_comb begin
    approach_d = approach_q;
    if (run_ok) begin
      if (err > brake) begin
        approach_d = 1'b1;
      end else if (err < near_lim) begin
        approach_d = 1'b0;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (is_run) begin
      if (!qualify) begin
        count_d = '0;
      end else if (count_q < cfg_i.arrive_frames) begin
        count_d = count_q + 8'd1;
      end
    end
  end

  always_comb begin
    target_d  = target_q;
    command_d = command_q;
    case (ctl_i.action)
      gpgs_pkg::ACT_RUN: begin
        if (ctl_i.comm_ok) begin
          command_d = $signed(cmd_run);
        end
      end
      gpgs_pkg::ACT_HOLD: begin
        if (ctl_i.comm_ok) begin
          command_d = $signed(hold_cmd);
          target_d  = load_position_i;
        end
      end
      gpgs_pkg::ACT_STOP: begin
        target_d  = '0;
        command_d = '0;
      end
      gpgs_pkg::ACT_SET_TARGET: begin
        target_d = $signed(set_tgt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      command_q  <= '0;
      load_q     <= '0;
      speed_q    <= '0;
      approach_q <= 1'b1;
      count_q    <= '0;
    end else if (fire_i) begin
      target_q   <= target_d;
      command_q  <= command_d;
      load_q     <= load_d;
      speed_q    <= speed_d;
      approach_q <= approach_d;
      count_q    <= count_d;
    end
  end

  // Result values, angles saturated to 32 bits.
  assign cmd_out_ext  = PW'(command_d);
  assign tgt_out_ext  = PW'(target_d);
  assign load_out_ext = PW'(load_d);
  gpgs_sat #(.IW(PW), .OW(32)) u_sat_ocmd  (.in_i(cmd_out_ext),  .out_o(rotor_command_o));
  gpgs_sat #(.IW(PW), .OW(32)) u_sat_otgt  (.in_i(tgt_out_ext),  .out_o(target_position_o));
  gpgs_sat #(.IW(PW), .OW(32)) u_sat_oload (.in_i(load_out_ext), .out_o(load_position_o));

  assign status_o       = (is_run || is_hold) && !ctl_i.comm_ok && !is_stop && !is_set;
  assign use_far_gain_o = approach_d;
  assign arrived_o      = (count_d >= cfg_i.arrive_frames);

endmodule

### rtl/core/geared_position_gain_scheduler_top.sv
// Top level of the geared position gain scheduler: handshake control and
// result register. Depends on gpgs_pkg, gpgs_cfg, gpgs_front, gpgs_core.
//
//   channel  handshake              payload
//   input    in_valid_i/in_stall_o  action, comm_ok, rotor_position/speed, new_target
//   result   out_valid_o/out_stall_i status, rotor_command, use_far_gain, target/load, arrived
//   config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle while the result is not stalled; the input register holds the
// load-side products, the state update feeds the result register.
// Reset is asynchronous and clears state, configuration and valid flags.
// A result stalled at the output holds; the input register still takes one
// more transaction, then in_stall_o rises until the result is taken.
module geared_position_gain_scheduler_top #(
  parameter int unsigned AngleBits = gpgs_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic                                comm_ok_i,
  input  logic signed [31:0]                  rotor_position_i,
  input  logic signed [31:0]                  rotor_speed_i,
  input  logic signed [31:0]                  new_target_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                status_o,
  output logic signed [31:0]                  rotor_command_o,
  output logic                                use_far_gain_o,
  output logic signed [31:0]                  target_position_o,
  output logic signed [31:0]                  load_position_o,
  output logic                                arrived_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gpgs_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  gpgs_pkg::cfg_t              cfg;
  gpgs_pkg::item_ctl_t         ctl;
  logic signed [31:0]          rpos, ntgt;
  logic signed [AngleBits-1:0] lpos, lspd;

  logic        advance, front_load, fire;
  logic        res_status, res_far, res_arrived;
  logic [31:0] res_cmd, res_tgt, res_load;

  logic        out_vld_q, out_vld_d;
  logic        status_q, far_q, arrived_q;
  logic [31:0] cmd_q, tgt_q, load_q;

  assign advance    = !out_vld_q || !out_stall_i;
  assign front_load = !ctl.valid || advance;
  assign fire       = ctl.valid && advance;
  assign in_stall_o = !front_load;

  gpgs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  gpgs_front #(.AngleBits(AngleBits)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (front_load),
    .in_valid_i       (in_valid_i),
    .action_i         (action_i),
    .comm_ok_i        (comm_ok_i),
    .rotor_position_i (rotor_position_i),
    .rotor_speed_i    (rotor_speed_i),
    .new_target_i     (new_target_i),
    .recip_i          (cfg.gear_ratio_recip),
    .ctl_o            (ctl),
    .rotor_position_o (rpos),
    .new_target_o     (ntgt),
    .load_position_o  (lpos),
    .load_speed_o     (lspd)
  );

  gpgs_core #(.AngleBits(AngleBits)) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .ctl_i             (ctl),
    .rotor_position_i  (rpos),
    .new_target_i      (ntgt),
    .load_position_i   (lpos),
    .load_speed_i      (lspd),
    .cfg_i             (cfg),
    .status_o          (res_status),
    .rotor_command_o   (res_cmd),
    .use_far_gain_o    (res_far),
    .target_position_o (res_tgt),
    .load_position_o   (res_load),
    .arrived_o         (res_arrived)
  );

  assign out_vld_d = advance ? ctl.valid : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= res_status;
      cmd_q     <= res_cmd;
      far_q     <= res_far;
      tgt_q     <= res_tgt;
      load_q    <= res_load;
      arrived_q <= res_arrived;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = status_q;
  assign rotor_command_o   = $signed(cmd_q);
  assign use_far_gain_o    = far_q;
  assign target_position_o = $signed(tgt_q);
  assign load_position_o   = $signed(load_q);
  assign arrived_o         = arrived_q;

endmodule

### rtl/core/gpgs_checker.sv
// Port-level assertions for the scheduler top level, bound to it below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gpgs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [31:0]                  rotor_command_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o
);

  // A stalled result stays and keeps its command.
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(rotor_command_o), "stalled result changed")

  // Input back-pressure only comes from a stalled result.
  `ASSERT_STD(a_stall_cause, !(out_valid_o && out_stall_i) |-> !in_stall_o, "input stalled without output stall")

  // A new result follows an earlier accepted transaction.
  `ASSERT_STD(a_result_origin, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "result without transaction")

  // Register writes are never refused.
  `ASSERT_STD(a_cfg_ready, cfg_valid_i |-> cfg_ready_o, "config write refused")

endmodule

bind geared_position_gain_scheduler_top gpgs_checker u_gpgs_checker (.*);

### sim/gpgs_tb_pkg.sv
// Scoreboard for the geared position gain scheduler testbench: result type,
// saturation helpers and a class that predicts and checks each result.
// Depends on gpgs_pkg.
package gpgs_tb_pkg;
  import gpgs_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        status;
    logic [31:0] rotor_command;
    logic        use_far_gain;
    logic [31:0] target_position;
    logic [31:0] load_position;
    logic        arrived;
  } sched_result_t;

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  class gain_schedule_scoreboard;
    cfg_t          cfg;
    longint        target_angle;
    longint        command_angle;
    longint        load_angle;
    longint        load_speed;
    bit            approaching;
    int            stable_count;
    sched_result_t pending[$];
    int            items_noted;
    int            results_checked;
    int            failures;

    function new();
      cfg = CFG_RESET;
      target_angle = 0;
      command_angle = 0;
      load_angle = 0;
      load_speed = 0;
      approaching = 1'b1;
      stable_count = 0;
      items_noted = 0;
      results_checked = 0;
      failures = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function longint to_load(longint rotor);
      return clamp_word((rotor * longint'(cfg.gear_ratio_recip)) >>> 16);
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_FAR_ERR_LIMIT:      cfg.far_err_limit = data[30:0];
        CFG_NEAR_HYST:          cfg.near_hyst = data[30:0];
        CFG_ARRIVE_POS_LIMIT:   cfg.arrive_pos_limit = data[30:0];
        CFG_ARRIVE_SPEED_LIMIT: cfg.arrive_speed_limit = data[30:0];
        CFG_ARRIVE_FRAMES:      cfg.arrive_frames = data[7:0];
        CFG_GEAR_RATIO:         cfg.gear_ratio = data[15:0];
        CFG_GEAR_RATIO_RECIP:   cfg.gear_ratio_recip = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_item(action_e act, bit ok, int rpos, int rspd, int ntgt);
      longint        err;
      longint        brake;
      sched_result_t r;
      brake = longint'(cfg.far_err_limit);
      r.status = 1'b0;
      items_noted++;
      case (act)
        ACT_RUN: begin
          if (ok) begin
            load_angle = to_load(longint'(rpos));
            load_speed = to_load(longint'(rspd));
            err = magnitude(target_angle - load_angle);
            if (err > brake) approaching = 1'b1;
            else if (err < brake - longint'(cfg.near_hyst)) approaching = 1'b0;
            command_angle = clamp_word((target_angle * longint'(cfg.gear_ratio)) >>> 8);
          end else begin
            r.status = 1'b1;
          end
          if (magnitude(target_angle - load_angle) < longint'(cfg.arrive_pos_limit) &&
              magnitude(load_speed) < longint'(cfg.arrive_speed_limit)) begin
            if (stable_count < int'(cfg.arrive_frames)) stable_count++;
          end else begin
            stable_count = 0;
          end
        end
        ACT_HOLD: begin
          if (ok) begin
            command_angle = longint'(rpos);
            target_angle = to_load(longint'(rpos));
          end else begin
            r.status = 1'b1;
          end
        end
        ACT_STOP: begin
          target_angle = 0;
          command_angle = 0;
        end
        default: target_angle = longint'(ntgt);
      endcase
      r.rotor_command = 32'(clamp_word(command_angle));
      r.use_far_gain = approaching;
      r.target_position = 32'(clamp_word(target_angle));
      r.load_position = 32'(clamp_word(load_angle));
      r.arrived = (stable_count >= int'(cfg.arrive_frames));
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      results_checked++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with no transaction outstanding",
                         results_checked));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.rotor_command !== want.rotor_command ||
          got.use_far_gain !== want.use_far_gain ||
          got.target_position !== want.target_position ||
          got.load_position !== want.load_position || got.arrived !== want.arrived) begin
        failures++;
        if (failures <= 10) begin
          $display("result %0d mismatch: exp st=%b cmd=%h far=%b tgt=%h load=%h arr=%b",
                   results_checked, want.status, want.rotor_command,
                   want.use_far_gain, want.target_position, want.load_position,
                   want.arrived);
          $display("  got st=%b cmd=%h far=%b tgt=%h load=%h arr=%b",
                   got.status, got.rotor_command, got.use_far_gain,
                   got.target_position, got.load_position, got.arrived);
        end
      end
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// Self-checking testbench for geared_position_gain_scheduler_top: directed and
// random feedback frames and commands under several register settings.
// Depends on gpgs_pkg and gpgs_tb_pkg.
module tb_top;
  import gpgs_pkg::*;
  import gpgs_tb_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 60;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                action_i;
  logic                      comm_ok_i;
  logic signed [31:0]        rotor_position_i;
  logic signed [31:0]        rotor_speed_i;
  logic signed [31:0]        new_target_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      status_o;
  logic signed [31:0]        rotor_command_o;
  logic                      use_far_gain_o;
  logic signed [31:0]        target_position_o;
  logic signed [31:0]        load_position_o;
  logic                      arrived_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [31:0]               cfg_data_i;

  gain_schedule_scoreboard sb;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 79;
  int          hold_request = 0;
  int          hold_left = 0;
  int          settings_applied = 0;

  geared_position_gain_scheduler_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  // output stall: long hold-off on request, otherwise random
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(sched_result_t'{status_o, rotor_command_o, use_far_gain_o,
                                      target_position_o, load_position_o, arrived_o});
  end

  task automatic send_item(action_e act, bit ok, int rpos, int rspd, int ntgt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    comm_ok_i <= ok;
    rotor_position_i <= rpos;
    rotor_speed_i <= rspd;
    new_target_i <= ntgt;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_item(act, ok, rpos, rspd, ntgt);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(CFG_FAR_ERR_LIMIT, 32'(c.far_err_limit));
    write_reg(CFG_NEAR_HYST, 32'(c.near_hyst));
    write_reg(CFG_ARRIVE_POS_LIMIT, 32'(c.arrive_pos_limit));
    write_reg(CFG_ARRIVE_SPEED_LIMIT, 32'(c.arrive_speed_limit));
    write_reg(CFG_ARRIVE_FRAMES, 32'(c.arrive_frames));
    write_reg(CFG_GEAR_RATIO, 32'(c.gear_ratio));
    write_reg(CFG_GEAR_RATIO_RECIP, 32'(c.gear_ratio_recip));
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.far_err_limit = 31'($urandom_range(200000));
    c.near_hyst = 31'($urandom_range(60000));
    c.arrive_pos_limit = 31'($urandom_range(30000));
    c.arrive_speed_limit = 31'($urandom_range(30000));
    c.arrive_frames = 8'($urandom_range(8));
    c.gear_ratio = 16'($urandom_range(4096, 257));
    c.gear_ratio_recip = 16'((1 << 24) / int'(c.gear_ratio));
    return c;
  endfunction

  // rotor angle whose load-side value lands near the current target
  function automatic int near_rotor();
    longint off;
    longint brake;
    longint hyst;
    brake = longint'(sb.cfg.far_err_limit);
    hyst = longint'(sb.cfg.near_hyst);
    case ($urandom_range(3))
      0: off = longint'($urandom) % (2 * longint'(sb.cfg.arrive_pos_limit) + 8);
      1: off = magnitude(brake - hyst - 4 + longint'($urandom) % (hyst + 9));
      2: off = longint'($urandom) >> $urandom_range(31, 0);
      default: off = longint'($urandom_range(7));
    endcase
    if ($urandom_range(1) != 0) off = -off;
    return int'(clamp_word(((sb.target_angle + off) * longint'(sb.cfg.gear_ratio)) >>> 8));
  endfunction

  function automatic int slow_speed();
    longint off;
    if ($urandom_range(3) == 0) return $urandom;
    off = longint'($urandom) % (2 * longint'(sb.cfg.arrive_speed_limit) + 4);
    if ($urandom_range(1) != 0) off = -off;
    return int'(clamp_word((off * longint'(sb.cfg.gear_ratio)) >>> 8));
  endfunction

  task automatic send_random_item();
    int unsigned pick;
    action_e     act;
    bit          ok;
    int          rpos;
    int          rspd;
    int          ntgt;
    pick = $urandom_range(99);
    ok = ($urandom_range(1) != 0);
    rpos = $urandom;
    rspd = $urandom;
    ntgt = $urandom;
    if (pick < 55) begin
      act = ACT_RUN;
      ok = ($urandom_range(19) != 0);
      rpos = near_rotor();
      rspd = slow_speed();
    end else if (pick < 63) begin
      act = ACT_RUN;
      ok = 1'b0;
    end else if (pick < 73) begin
      act = ACT_RUN;
    end else if (pick < 81) begin
      act = ACT_HOLD;
      ok = ($urandom_range(4) != 0);
      if ($urandom_range(1) != 0) rpos = near_rotor();
    end else if (pick < 87) begin
      act = ACT_STOP;
    end else begin
      act = ACT_SET_TARGET;
      if ($urandom_range(2) != 0) ntgt = $signed($urandom) >>> $urandom_range(24, 4);
    end
    send_item(act, ok, rpos, rspd, ntgt);
  endtask

  task automatic run_block(int n, bit press);
    for (int i = 0; i < n; i++) begin
      if (press && i == n / 2) hold_request = HOLD_OFF_CYCLES;
      send_random_item();
    end
    drain();
  endtask

  task automatic run_directed();
    send_item(ACT_RUN, 1'b1, 0, 0, 0);
    send_item(ACT_RUN, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_RUN, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_RUN, 1'b0, 32'h1234_5678, 32'hFEDC_BA98, 0);
    send_item(ACT_SET_TARGET, 1'b0, 0, 0, 32'h7FFF_FFFF);
    send_item(ACT_RUN, 1'b1, 0, 0, 0);
    send_item(ACT_HOLD, 1'b1, 32'h8000_0000, 0, 0);
    send_item(ACT_HOLD, 1'b0, 32'h7FFF_FFFF, 0, 0);
    send_item(ACT_STOP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_SET_TARGET, 1'b1, 0, 0, 32'h8000_0000);
    send_item(ACT_RUN, 1'b1, 0, 0, 0);
    send_item(ACT_SET_TARGET, 1'b1, 0, 0, 100);
    // settle on the target until the arrival count saturates
    repeat (6) send_item(ACT_RUN, 1'b1, 632, 0, 0);
    send_item(ACT_RUN, 1'b0, 0, 32'h7FFF_FFFF, 0);
    send_item(ACT_SET_TARGET, 1'b1, 0, 0, -1);
    send_item(ACT_STOP, 1'b1, 0, 0, 0);
    send_item(ACT_RUN, 1'b1, -1, -1, 0);
    send_item(ACT_HOLD, 1'b1, -1, 0, 0);
    drain();
  endtask

  initial begin : main
    cfg_t plan[9];
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_RUN;
    comm_ok_i = 1'b0;
    rotor_position_i = '0;
    rotor_speed_i = '0;
    new_target_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FAR_ERR_LIMIT;
    cfg_data_i = '0;

    plan[0] = CFG_RESET;
    plan[0].arrive_frames = 8'd1;
    plan[1] = '{far_err_limit: '0, near_hyst: '0, arrive_pos_limit: '1,
                arrive_speed_limit: '1, arrive_frames: 8'd255,
                gear_ratio: 16'hFFFF, gear_ratio_recip: 16'd1};
    plan[2] = '{far_err_limit: '1, near_hyst: '1, arrive_pos_limit: '0,
                arrive_speed_limit: '0, arrive_frames: 8'd0,
                gear_ratio: 16'd256, gear_ratio_recip: 16'hFFFF};
    // hysteresis wider than the brake threshold
    plan[3] = '{far_err_limit: 31'd1000, near_hyst: 31'd5000, arrive_pos_limit: 31'd3000,
                arrive_speed_limit: 31'd3000, arrive_frames: 8'd3,
                gear_ratio: 16'd1620, gear_ratio_recip: 16'd10354};
    // gear values outside the nominal range
    plan[4] = '{far_err_limit: 31'd19661, near_hyst: 31'd3277, arrive_pos_limit: 31'd5243,
                arrive_speed_limit: 31'd9830, arrive_frames: 8'd2,
                gear_ratio: 16'd100, gear_ratio_recip: 16'd0};
    plan[5] = CFG_RESET;
    plan[6] = random_cfg();
    plan[7] = random_cfg();
    plan[8] = '{far_err_limit: '1, near_hyst: '0, arrive_pos_limit: '1,
                arrive_speed_limit: '1, arrive_frames: 8'd4,
                gear_ratio: 16'd512, gear_ratio_recip: 16'd32768};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int b = 0; b < 9; b++) begin
      if (b == 3) begin
        tx_idle_pct = 79;
        rx_idle_pct = 10;
      end else if (b == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_cfg(plan[b]);
      run_block(150, b == 1 || b == 7);
    end

    $display("Ran %0d transactions and checked %0d results over %0d register settings,",
             sb.items_noted, sb.results_checked, settings_applied + 1);
    $display("three idle profiles on both channels and two long output hold-offs.");
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
